// ----- hw/rtl/bdr_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debounce package
// Shared widths, register indexes, defaults and item types of the debouncer.
// ----------------------------------------------------------------------------
package bdr_pkg;

	localparam int TIME_BITS = 32;
	localparam int ADC_BITS  = 10;
	localparam int MS_BITS   = 16;
	localparam int EN_BITS   = 5;
	localparam int CFG_W     = 16;
	localparam int CFG_ADDR_W = 3;

	// Sample values at or below this read as a low level in analog mode.
	localparam logic [ADC_BITS-1:0] ANALOG_LOW_MAX = ADC_BITS'(200);

	localparam logic [MS_BITS-1:0] DEBOUNCE_RST    = MS_BITS'(100);
	localparam logic [MS_BITS-1:0] REPEAT_RST      = MS_BITS'(300);
	localparam logic [MS_BITS-1:0] START_DELAY_RST = MS_BITS'(500);
	localparam logic [MS_BITS-1:0] CLICK_RST       = MS_BITS'(250);
	localparam logic [MS_BITS-1:0] LONG_PRESS_RST  = MS_BITS'(1000);
	localparam logic [EN_BITS-1:0] EVENT_EN_RST    = EN_BITS'(7);

	// Bit positions in the event enable mask.
	localparam int EN_REPEAT = 0;
	localparam int EN_DOWN   = 1;
	localparam int EN_UP     = 2;
	localparam int EN_CLICK  = 3;
	localparam int EN_LONG   = 4;

	localparam int IN_BITS  = TIME_BITS + 1 + ADC_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 7 + TIME_BITS;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ANALOG_MODE = 3'd0,
		REG_DEBOUNCE    = 3'd1,
		REG_REPEAT      = 3'd2,
		REG_START_DELAY = 3'd3,
		REG_CLICK       = 3'd4,
		REG_LONG_PRESS  = 3'd5,
		REG_EVENT_EN    = 3'd6
	} bdr_reg_t;

	typedef struct packed {
		logic               analog_mode;
		logic [MS_BITS-1:0] debounce_ms;
		logic [MS_BITS-1:0] repeat_ms;
		logic [MS_BITS-1:0] start_delay_ms;
		logic [MS_BITS-1:0] click_ms;
		logic [MS_BITS-1:0] long_press_ms;
		logic [EN_BITS-1:0] event_enable;
	} bdr_cfg_t;

	typedef struct packed {
		logic [ADC_BITS-1:0]  analog_sample;
		logic                 raw_level;
		logic [TIME_BITS-1:0] now_ms;
	} bdr_in_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] held_ms;
		logic                 is_pressed;
		logic                 key_up;
		logic                 key_long_press;
		logic                 key_click;
		logic [1:0]           repeat_count;
		logic                 key_down;
	} bdr_out_t;

endpackage

// ----- hw/rtl/bdr_cfg.sv -----
// ----------------------------------------------------------------------------
// Button debounce configuration registers
// Holds the mode, timing and enable registers written through the write port.
// ----------------------------------------------------------------------------
module bdr_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bdr_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bdr_pkg::CFG_W-1:0]    cfg_data,
	output bdr_pkg::bdr_cfg_t            cfg
);
	import bdr_pkg::*;

	bdr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.analog_mode    <= 1'b0;
			cfg_q.debounce_ms    <= DEBOUNCE_RST;
			cfg_q.repeat_ms      <= REPEAT_RST;
			cfg_q.start_delay_ms <= START_DELAY_RST;
			cfg_q.click_ms       <= CLICK_RST;
			cfg_q.long_press_ms  <= LONG_PRESS_RST;
			cfg_q.event_enable   <= EVENT_EN_RST;
		end else if (cfg_we) begin
			unique case (bdr_reg_t'(cfg_addr))
				REG_ANALOG_MODE: cfg_q.analog_mode    <= cfg_data[0];
				REG_DEBOUNCE:    cfg_q.debounce_ms    <= cfg_data[MS_BITS-1:0];
				REG_REPEAT:      cfg_q.repeat_ms      <= cfg_data[MS_BITS-1:0];
				REG_START_DELAY: cfg_q.start_delay_ms <= cfg_data[MS_BITS-1:0];
				REG_CLICK:       cfg_q.click_ms       <= cfg_data[MS_BITS-1:0];
				REG_LONG_PRESS:  cfg_q.long_press_ms  <= cfg_data[MS_BITS-1:0];
				REG_EVENT_EN:    cfg_q.event_enable   <= cfg_data[EN_BITS-1:0];
				default: begin
					// Unknown indexes are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hw/rtl/bdr_core.sv -----
// ----------------------------------------------------------------------------
// Button debounce event core
// Debounce state and the per-poll event decision, one poll per step.
// ----------------------------------------------------------------------------
module bdr_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  bdr_pkg::bdr_in_t   poll,
	input  bdr_pkg::bdr_cfg_t  cfg,
	output bdr_pkg::bdr_out_t  result
);
	import bdr_pkg::*;

	logic                 stable_level_q;
	logic [TIME_BITS-1:0] change_time_q;
	logic                 held_q;
	logic [TIME_BITS-1:0] press_time_q;
	logic [TIME_BITS-1:0] last_rep_q;

	logic                 level;
	logic                 accepted;
	logic                 changed;
	logic                 new_press;
	logic                 release_ev;
	logic                 rep_en;
	logic                 rep_timed;
	logic                 rep_tick;
	logic [TIME_BITS-1:0] since_change;
	logic [TIME_BITS-1:0] since_press;
	logic [TIME_BITS-1:0] since_press_new;
	logic [TIME_BITS-1:0] since_rep;
	logic [TIME_BITS-1:0] press_time_d;
	logic [TIME_BITS-1:0] last_rep_d;
	logic                 held_d;
	logic [1:0]           reps;

	always_comb begin
		level = cfg.analog_mode ? (poll.analog_sample > ANALOG_LOW_MAX) : poll.raw_level;

		since_change = poll.now_ms - change_time_q;
		changed      = (level != stable_level_q);
		accepted     = !changed || (since_change >= TIME_BITS'(cfg.debounce_ms));

		new_press  = accepted && !level && !held_q;
		release_ev = accepted && level && held_q;

		since_press     = poll.now_ms - press_time_q;
		// A fresh press starts its hold time at this poll.
		since_press_new = new_press ? '0 : since_press;
		since_rep       = poll.now_ms - last_rep_q;

		rep_en    = cfg.event_enable[EN_REPEAT];
		rep_timed = accepted && !level && rep_en && (cfg.repeat_ms != '0);
		rep_tick  = rep_timed && (since_press_new >= TIME_BITS'(cfg.start_delay_ms))
			&& (since_rep > TIME_BITS'(cfg.repeat_ms));

		reps = 2'((new_press && rep_en) ? 1 : 0) + 2'(rep_tick ? 1 : 0);

		press_time_d = new_press ? poll.now_ms : press_time_q;
		held_d       = accepted ? !level : held_q;

		priority if (accepted && level) begin
			last_rep_d = '0;
		end else if (rep_timed && (since_press_new < TIME_BITS'(cfg.start_delay_ms))) begin
			last_rep_d = poll.now_ms;
		end else if (rep_tick) begin
			last_rep_d = poll.now_ms;
		end else begin
			last_rep_d = last_rep_q;
		end

		result.key_down       = new_press && cfg.event_enable[EN_DOWN];
		result.repeat_count   = reps;
		result.key_click      = release_ev && cfg.event_enable[EN_CLICK]
			&& (since_press <= TIME_BITS'(cfg.click_ms));
		result.key_long_press = release_ev && cfg.event_enable[EN_LONG]
			&& (since_press >= TIME_BITS'(cfg.long_press_ms));
		result.key_up         = release_ev && cfg.event_enable[EN_UP];
		result.is_pressed     = held_d;
		result.held_ms        = held_d ? since_press_new : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_level_q <= 1'b1;
			change_time_q  <= '0;
			held_q         <= 1'b0;
			press_time_q   <= '0;
			last_rep_q     <= '0;
		end else if (step) begin
			if (accepted && changed) begin
				stable_level_q <= level;
				change_time_q  <= poll.now_ms;
			end
			held_q       <= held_d;
			press_time_q <= press_time_d;
			last_rep_q   <= last_rep_d;
		end
	end

endmodule

// ----- hw/rtl/button_debounce_repeat_events.sv -----
// ----------------------------------------------------------------------------
// Button debounce with auto-repeat events
// Top level: poll input register, event core and result register.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one poll of the button: the time in
// milliseconds, the digital pin level and an analog sample. Each poll gives
// exactly one result request on the master stream with the key down, repeat,
// click, long press and key up events, the held flag and the hold time.
// The configuration port writes one register per cycle while cfg_we is high;
// it is meant to be written while no poll is in flight.
// A poll is taken into the input register and evaluated against the debounce
// state when it advances, landing in the result register at that edge, from
// which the result is offered. One poll per cycle is taken back to back while
// the receiver does not stall.
// When the receiver stalls, the held result waits and one further poll waits
// in the input register; s_tready falls only when both are full.
// Reset clears both stages, restores the register defaults and returns the
// button to the released state.
// ----------------------------------------------------------------------------
module button_debounce_repeat_events (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// now_ms[31:0], raw_level[32], analog_sample[42:33], zero fill
	input  logic [bdr_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// key_down[0], repeat_count[2:1], key_click[3], key_long_press[4],
	// key_up[5], is_pressed[6], held_ms[38:7], zero fill
	output logic [bdr_pkg::OUT_W-1:0]      m_tdata,
	input  logic                           cfg_we,
	input  logic [bdr_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [bdr_pkg::CFG_W-1:0]      cfg_data
);
	import bdr_pkg::*;

	bdr_cfg_t cfg;
	bdr_in_t  poll_s1;
	logic     valid_s1;
	bdr_out_t result;
	bdr_out_t result_s2;
	logic     valid_s2;
	logic     advance;

	bdr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			poll_s1 <= bdr_in_t'(s_tdata[IN_BITS-1:0]);
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	bdr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.poll   (poll_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OUT_W - OUT_BITS)'(0), result_s2};

endmodule
